@@ hdl/lnf_pkg.sv @@
// Shared types, widths and codes for the layer normalisation forward block.
`default_nettype none
package lnf_pkg;

    // Field and accumulator widths.
    localparam int DATA_W  = 16;
    localparam int CNT_W   = 13;
    localparam int SUM_W   = 28;
    localparam int SSQ_W   = 42;
    localparam int RSTD_W  = 32;
    localparam int EPS_W   = 32;
    localparam int PROD_W  = 55;
    localparam int NN_W    = 26;
    localparam int DIV_NW  = 65;
    localparam int DIV_DW  = 56;
    localparam int DIV_CW  = 7;
    localparam int SQRT_W  = 64;
    localparam int SQRT_IW = 5;
    localparam int ADDR_W  = 4;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd168;

    // Register index within the configuration space.
    typedef enum logic [1:0] {
        REG_EPSILON   = 2'd0,
        REG_USE_GAMMA = 2'd1,
        REG_USE_BETA  = 2'd2
    } reg_idx_t;

    typedef enum logic {
        OP_STATS = 1'b0,
        OP_NORM  = 1'b1
    } op_t;

    typedef enum logic {
        KIND_STATS = 1'b0,
        KIND_NORM  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        DIV_MEAN = 2'd0,
        DIV_VAR  = 2'd1,
        DIV_RSQ  = 2'd2
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LATCH,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_NSQ_LO,
        ST_NSQ_HI,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_RSQ_GO,
        ST_RSQ_WAIT,
        ST_SQRT,
        ST_STAT_OUT,
        ST_NORM1,
        ST_NORM2,
        ST_NORM_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     acc;
        logic     latch;
        logic     div_start;
        div_sel_t div_sel;
        logic     mean_store;
        logic     nsq_lo;
        logic     nsq_hi;
        logic     var_store;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     stat_out;
        logic     norm1;
        logic     norm2;
        logic     norm_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic sqrt_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ hdl/lnf_in_if.sv @@
// Input channel carrying one element per transfer.
`default_nettype none
interface lnf_in_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic signed [lnf_pkg::DATA_W-1:0]  x_sample;
    logic signed [lnf_pkg::DATA_W-1:0]  gamma;
    logic signed [lnf_pkg::DATA_W-1:0]  beta;
    logic                               last_in_row;

    modport source (output valid, op, x_sample, gamma, beta, last_in_row, input ready);
    modport sink   (input valid, op, x_sample, gamma, beta, last_in_row, output ready);
endinterface
`default_nettype wire

@@ hdl/lnf_out_if.sv @@
// Output channel carrying one result per transfer.
`default_nettype none
interface lnf_out_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic signed [lnf_pkg::DATA_W-1:0]  y_out;
    logic signed [lnf_pkg::DATA_W-1:0]  row_mean;
    logic [lnf_pkg::RSTD_W-1:0]         row_rstd;

    modport source (output valid, kind, y_out, row_mean, row_rstd, input ready);
    modport sink   (input valid, kind, y_out, row_mean, row_rstd, output ready);
endinterface
`default_nettype wire

@@ hdl/lnf_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module lnf_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [lnf_pkg::DIV_NW-1:0]   num,
    input  wire logic [lnf_pkg::DIV_DW-1:0]   den,
    output logic      [lnf_pkg::DIV_NW-1:0]   quo,
    output logic                              done
);

    logic [lnf_pkg::DIV_NW-1:0] num_reg, num_next;
    logic [lnf_pkg::DIV_DW-1:0] den_reg;
    logic [lnf_pkg::DIV_DW-1:0] rem_reg, rem_next;
    logic [lnf_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [lnf_pkg::DIV_DW:0]   rem_shift;
    logic                       fits;

    // One shift and trial subtraction per cycle; quotient bits replace the numerator.
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[lnf_pkg::DIV_NW-1]};
        fits      = (rem_shift >= {1'b0, den_reg});
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            cnt_next  = lnf_pkg::DIV_CW'(lnf_pkg::DIV_NW);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[lnf_pkg::DIV_NW-2:0], fits};
            rem_next = fits ? lnf_pkg::DIV_DW'(rem_shift - {1'b0, den_reg})
                            : rem_shift[lnf_pkg::DIV_DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lnf_pkg::DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Operand and quotient registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quo  = num_reg;
    assign done = done_reg;

    a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !done_reg)
        else $error("divider reports done straight after a start");
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg))
        else $error("divider is busy and done at once");

endmodule
`default_nettype wire

@@ hdl/lnf_datapath.sv @@
// Accumulators, statistics arithmetic, normalisation pipeline and output register.
`default_nettype none
module lnf_datapath #(
    parameter int ROW_LEN = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lnf_pkg::cmd_t                       cmd,
    output lnf_pkg::status_t                         sts,
    input  wire logic signed [lnf_pkg::DATA_W-1:0]   in_x,
    input  wire logic signed [lnf_pkg::DATA_W-1:0]   in_gamma,
    input  wire logic signed [lnf_pkg::DATA_W-1:0]   in_beta,
    input  wire logic [lnf_pkg::EPS_W-1:0]           epsilon,
    input  wire logic                                use_gamma,
    input  wire logic                                use_beta,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic                                     out_kind,
    output logic signed [lnf_pkg::DATA_W-1:0]        out_y,
    output logic signed [lnf_pkg::DATA_W-1:0]        out_mean,
    output logic [lnf_pkg::RSTD_W-1:0]               out_rstd
);

    localparam int P1_W   = 50;
    localparam int NORM_W = 42;
    localparam int P2_W   = 58;
    localparam int ACC_W  = 59;
    localparam int Y_W    = 37;
    localparam int HALF_W = 21;

    // Divide by 2^8, nearest, ties away from zero.
    function automatic logic signed [NORM_W-1:0] rnd8(input logic signed [P1_W-1:0] v);
        logic [P1_W-1:0] m;
        logic [P1_W-1:0] r;
        begin
            m = v[P1_W-1] ? P1_W'(-v) : P1_W'(v);
            r = (m + P1_W'(128)) >> 8;
            rnd8 = v[P1_W-1] ? -$signed(r[NORM_W-1:0]) : $signed(r[NORM_W-1:0]);
        end
    endfunction

    // Divide by 2^24, nearest, ties away from zero.
    function automatic logic signed [Y_W-1:0] rnd24(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        logic [ACC_W-1:0] r;
        begin
            m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
            r = (m + (ACC_W'(1) << 23)) >> 24;
            rnd24 = v[ACC_W-1] ? -$signed(r[Y_W-1:0]) : $signed(r[Y_W-1:0]);
        end
    endfunction

    logic [lnf_pkg::CNT_W-1:0]          cnt_reg, n_reg;
    logic signed [lnf_pkg::SUM_W-1:0]   sum_reg;
    logic [lnf_pkg::SSQ_W-1:0]          ssq_reg;
    logic signed [lnf_pkg::DATA_W-1:0]  mean_reg;
    logic [lnf_pkg::RSTD_W-1:0]         rstd_reg;
    logic [lnf_pkg::NN_W-1:0]           nn_reg;
    logic [lnf_pkg::PROD_W-1:0]         sq_reg, prod_reg;
    logic [lnf_pkg::DIV_DW-1:0]         work_reg;
    logic [lnf_pkg::SQRT_W-1:0]         srem_reg, sres_reg;
    logic [lnf_pkg::SQRT_IW-1:0]        sidx_reg;
    logic signed [lnf_pkg::DATA_W-1:0]  x_reg, g_reg, b_reg;
    logic signed [P1_W-1:0]             p1_reg;
    logic signed [P2_W-1:0]             p2_reg;
    logic                               out_valid_reg;
    logic                               out_kind_reg;
    logic signed [lnf_pkg::DATA_W-1:0]  out_y_reg, out_mean_reg;
    logic [lnf_pkg::RSTD_W-1:0]         out_rstd_reg;

    logic signed [2*lnf_pkg::DATA_W-1:0] x_sq;
    logic [lnf_pkg::SSQ_W:0]            ssq_sum;
    logic [lnf_pkg::SUM_W-1:0]          abs_sum;
    logic [lnf_pkg::CNT_W-1:0]          n_now;
    logic [lnf_pkg::PROD_W-1:0]         var_num;
    logic [lnf_pkg::DIV_NW-1:0]         div_num, div_quo;
    logic [lnf_pkg::DIV_DW-1:0]         div_den;
    logic                               div_done;
    logic [lnf_pkg::SUM_W:0]            mean_mag;
    logic signed [lnf_pkg::DATA_W-1:0]  mean_sat;
    logic [lnf_pkg::SQRT_W-1:0]         sbit, stest;
    logic [lnf_pkg::RSTD_W-1:0]         rstd_final;
    logic signed [lnf_pkg::DATA_W:0]    diff;
    logic signed [NORM_W-1:0]           norm_val;
    logic signed [lnf_pkg::DATA_W-1:0]  gm;
    logic signed [ACC_W-1:0]            y_acc;
    logic signed [Y_W-1:0]              y_rnd;
    logic signed [lnf_pkg::DATA_W-1:0]  y_sat;
    logic                               out_free;

    // Row statistics helpers.
    always_comb
    begin
        x_sq    = in_x * in_x;
        ssq_sum = {1'b0, ssq_reg} + (lnf_pkg::SSQ_W+1)'(unsigned'(x_sq));
        abs_sum = sum_reg[lnf_pkg::SUM_W-1] ? lnf_pkg::SUM_W'(-sum_reg)
                                            : lnf_pkg::SUM_W'(sum_reg);
        n_now   = (cnt_reg == '0) ? lnf_pkg::CNT_W'(1) : cnt_reg;
        var_num = (prod_reg > sq_reg) ? (prod_reg - sq_reg) : '0;
    end

    // Divider operand selection.
    always_comb
    begin
        case (cmd.div_sel)
            lnf_pkg::DIV_MEAN:
            begin
                div_num = lnf_pkg::DIV_NW'(abs_sum) + lnf_pkg::DIV_NW'(n_reg >> 1);
                div_den = lnf_pkg::DIV_DW'(n_reg);
            end
            lnf_pkg::DIV_VAR:
            begin
                div_num = lnf_pkg::DIV_NW'(var_num);
                div_den = lnf_pkg::DIV_DW'(nn_reg);
            end
            lnf_pkg::DIV_RSQ:
            begin
                div_num = lnf_pkg::DIV_NW'(1) << lnf_pkg::SQRT_W;
                div_den = work_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    lnf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    // Mean clamp, square root step and final rstd.
    always_comb
    begin
        mean_mag = div_quo[lnf_pkg::SUM_W:0];
        if (sum_reg[lnf_pkg::SUM_W-1])
        begin
            mean_sat = (mean_mag > (lnf_pkg::SUM_W+1)'(32768)) ? 16'sh8000
                     : -$signed(mean_mag[lnf_pkg::DATA_W-1:0]);
        end
        else
        begin
            mean_sat = (mean_mag > (lnf_pkg::SUM_W+1)'(32767)) ? 16'sh7fff
                     : $signed(mean_mag[lnf_pkg::DATA_W-1:0]);
        end
        sbit  = lnf_pkg::SQRT_W'(1) << {sidx_reg, 1'b0};
        stest = sres_reg + sbit;
        if (work_reg <= lnf_pkg::DIV_DW'(1) || sres_reg[lnf_pkg::SQRT_W-1:lnf_pkg::RSTD_W] != '0)
        begin
            rstd_final = '1;
        end
        else
        begin
            rstd_final = sres_reg[lnf_pkg::RSTD_W-1:0];
        end
    end

    // Normalisation arithmetic.
    always_comb
    begin
        diff     = {x_reg[lnf_pkg::DATA_W-1], x_reg} - {mean_reg[lnf_pkg::DATA_W-1], mean_reg};
        norm_val = rnd8(p1_reg);
        gm       = use_gamma ? g_reg : 16'sd4096;
        y_acc    = ACC_W'(p2_reg) + (use_beta ? (ACC_W'(b_reg) <<< 24) : ACC_W'(0));
        y_rnd    = rnd24(y_acc);
        if (y_rnd > Y_W'(32767))
        begin
            y_sat = 16'sh7fff;
        end
        else if (y_rnd < -Y_W'(32768))
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat = y_rnd[lnf_pkg::DATA_W-1:0];
        end
        out_free = !out_valid_reg || out_ready;
    end

    // Accumulators and held row statistics.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            ssq_reg  <= '0;
            mean_reg <= '0;
            rstd_reg <= '0;
        end
        else
        begin
            if (cmd.acc && cnt_reg < lnf_pkg::CNT_W'(ROW_LEN))
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sum_reg <= sum_reg + lnf_pkg::SUM_W'(in_x);
                ssq_reg <= ssq_sum[lnf_pkg::SSQ_W] ? '1 : ssq_sum[lnf_pkg::SSQ_W-1:0];
            end
            else if (cmd.stat_out)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                ssq_reg <= '0;
            end
            if (cmd.mean_store)
            begin
                mean_reg <= mean_sat;
            end
            if (cmd.stat_out)
            begin
                rstd_reg <= rstd_final;
            end
        end
    end

    // Working registers of the row-close sequence and the normalise steps.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg <= in_x;
            g_reg <= in_gamma;
            b_reg <= in_beta;
        end
        if (cmd.latch)
        begin
            n_reg  <= n_now;
            nn_reg <= lnf_pkg::NN_W'(n_now * n_now);
            sq_reg <= lnf_pkg::PROD_W'(abs_sum * abs_sum);
        end
        if (cmd.nsq_lo)
        begin
            prod_reg <= lnf_pkg::PROD_W'(n_reg * ssq_reg[HALF_W-1:0]);
        end
        if (cmd.nsq_hi)
        begin
            prod_reg <= prod_reg
                      + (lnf_pkg::PROD_W'(n_reg * ssq_reg[lnf_pkg::SSQ_W-1:HALF_W]) << HALF_W);
        end
        if (cmd.var_store)
        begin
            work_reg <= div_quo[lnf_pkg::DIV_DW-1:0] + lnf_pkg::DIV_DW'(epsilon);
        end
        if (cmd.sqrt_init)
        begin
            srem_reg <= div_quo[lnf_pkg::SQRT_W-1:0];
            sres_reg <= '0;
            sidx_reg <= '1;
        end
        else if (cmd.sqrt_step)
        begin
            if (srem_reg >= stest)
            begin
                srem_reg <= srem_reg - stest;
                sres_reg <= (sres_reg >> 1) + sbit;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sidx_reg <= sidx_reg - 1'b1;
        end
        if (cmd.norm1)
        begin
            p1_reg <= diff * $signed({1'b0, rstd_reg});
        end
        if (cmd.norm2)
        begin
            p2_reg <= norm_val * gm;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.stat_out || cmd.norm_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (cmd.stat_out)
        begin
            out_kind_reg <= lnf_pkg::KIND_STATS;
            out_y_reg    <= '0;
            out_mean_reg <= mean_reg;
            out_rstd_reg <= rstd_final;
        end
        else if (cmd.norm_out)
        begin
            out_kind_reg <= lnf_pkg::KIND_NORM;
            out_y_reg    <= y_sat;
            out_mean_reg <= mean_reg;
            out_rstd_reg <= rstd_reg;
        end
    end

    assign sts.div_done  = div_done;
    assign sts.sqrt_last = (sidx_reg == '0);
    assign sts.out_free  = out_free;
    assign out_valid     = out_valid_reg;
    assign out_kind      = out_kind_reg;
    assign out_y         = out_y_reg;
    assign out_mean      = out_mean_reg;
    assign out_rstd      = out_rstd_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= lnf_pkg::CNT_W'(ROW_LEN))
        else $error("element count exceeds the row length");
    a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.stat_out |=> (cnt_reg == '0 && sum_reg == '0 && ssq_reg == '0))
        else $error("accumulators not cleared after a row closed");

endmodule
`default_nettype wire

@@ hdl/lnf_ctrl.sv @@
// Controller that sequences accumulation, row close and normalisation.
`default_nettype none
module lnf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_op,
    input  wire logic               in_last,
    output logic                    in_ready,
    input  wire lnf_pkg::status_t   sts,
    output lnf_pkg::cmd_t           cmd
);

    lnf_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lnf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = lnf_pkg::DIV_MEAN;
        in_ready    = 1'b0;
        case (state_reg)
            lnf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_op == lnf_pkg::OP_STATS)
                    begin
                        cmd.acc = 1'b1;
                        if (in_last)
                        begin
                            state_next = lnf_pkg::ST_LATCH;
                        end
                    end
                    else
                    begin
                        state_next = lnf_pkg::ST_NORM1;
                    end
                end
            end
            lnf_pkg::ST_LATCH:
            begin
                cmd.latch  = 1'b1;
                state_next = lnf_pkg::ST_MEAN_GO;
            end
            lnf_pkg::ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lnf_pkg::DIV_MEAN;
                state_next    = lnf_pkg::ST_MEAN_WAIT;
            end
            lnf_pkg::ST_MEAN_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.mean_store = 1'b1;
                    state_next     = lnf_pkg::ST_NSQ_LO;
                end
            end
            lnf_pkg::ST_NSQ_LO:
            begin
                cmd.nsq_lo = 1'b1;
                state_next = lnf_pkg::ST_NSQ_HI;
            end
            lnf_pkg::ST_NSQ_HI:
            begin
                cmd.nsq_hi = 1'b1;
                state_next = lnf_pkg::ST_VAR_GO;
            end
            lnf_pkg::ST_VAR_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lnf_pkg::DIV_VAR;
                state_next    = lnf_pkg::ST_VAR_WAIT;
            end
            lnf_pkg::ST_VAR_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.var_store = 1'b1;
                    state_next    = lnf_pkg::ST_RSQ_GO;
                end
            end
            lnf_pkg::ST_RSQ_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lnf_pkg::DIV_RSQ;
                state_next    = lnf_pkg::ST_RSQ_WAIT;
            end
            lnf_pkg::ST_RSQ_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = lnf_pkg::ST_SQRT;
                end
            end
            lnf_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                begin
                    state_next = lnf_pkg::ST_STAT_OUT;
                end
            end
            lnf_pkg::ST_STAT_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.stat_out = 1'b1;
                    state_next   = lnf_pkg::ST_IDLE;
                end
            end
            lnf_pkg::ST_NORM1:
            begin
                cmd.norm1  = 1'b1;
                state_next = lnf_pkg::ST_NORM2;
            end
            lnf_pkg::ST_NORM2:
            begin
                cmd.norm2  = 1'b1;
                state_next = lnf_pkg::ST_NORM_OUT;
            end
            lnf_pkg::ST_NORM_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.norm_out = 1'b1;
                    state_next   = lnf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lnf_pkg::ST_IDLE;
            end
        endcase
    end

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sts.div_done) |-> (state_reg == lnf_pkg::ST_MEAN_WAIT
                                 || state_reg == lnf_pkg::ST_VAR_WAIT
                                 || state_reg == lnf_pkg::ST_RSQ_WAIT))
        else $error("division finished outside a wait state");

endmodule
`default_nettype wire

@@ hdl/layer_norm_forward_core.sv @@
// Top level of the layer normalisation forward block with its register port.
`default_nettype none
// Rows are fed twice: a statistics pass (op 0) and a normalise pass (op 1).
// A statistics element that does not close its row is accumulated while the
// controller stays idle. The element that closes a row starts a sequence on
// the shared one-bit-per-cycle divider (mean, variance and 2^64/(var+eps),
// each quotient taken by the controller in its wait state on done) followed
// by a 32-step integer square root; the row statistics result is then issued.
// A normalise element passes through NORM1 and NORM2, its two registered
// multiplies, and NORM_OUT. A new element is taken whenever the controller is
// idle, even while the previous result still waits in the output register.
// There is no clearing pass after reset.
module layer_norm_forward_core #(
    parameter int ROW_LEN = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lnf_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    lnf_in_if.sink                             din,
    lnf_out_if.source                          dout
);

    logic [lnf_pkg::EPS_W-1:0] epsilon_reg;
    logic                      use_gamma_reg;
    logic                      use_beta_reg;
    lnf_pkg::reg_idx_t         reg_idx;
    logic                      wr_en;
    lnf_pkg::cmd_t             cmd;
    lnf_pkg::status_t          sts;

    assign reg_idx = lnf_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Configuration registers, written on the access phase of a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg   <= lnf_pkg::EPS_RESET;
            use_gamma_reg <= 1'b1;
            use_beta_reg  <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lnf_pkg::REG_EPSILON:   epsilon_reg   <= pwdata;
                lnf_pkg::REG_USE_GAMMA: use_gamma_reg <= pwdata[0];
                lnf_pkg::REG_USE_BETA:  use_beta_reg  <= pwdata[0];
                default:                epsilon_reg   <= epsilon_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            lnf_pkg::REG_EPSILON:   prdata = epsilon_reg;
            lnf_pkg::REG_USE_GAMMA: prdata = {31'd0, use_gamma_reg};
            lnf_pkg::REG_USE_BETA:  prdata = {31'd0, use_beta_reg};
            default:                prdata = '0;
        endcase
    end

    lnf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_op    (din.op),
        .in_last  (din.last_in_row),
        .in_ready (din.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lnf_datapath #(
        .ROW_LEN (ROW_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_x      (din.x_sample),
        .in_gamma  (din.gamma),
        .in_beta   (din.beta),
        .epsilon   (epsilon_reg),
        .use_gamma (use_gamma_reg),
        .use_beta  (use_beta_reg),
        .out_ready (dout.ready),
        .out_valid (dout.valid),
        .out_kind  (dout.kind),
        .out_y     (dout.y_out),
        .out_mean  (dout.row_mean),
        .out_rstd  (dout.row_rstd)
    );

endmodule
`default_nettype wire
